// ----- rtl/dsts_pkg.sv -----
`default_nettype none
package dsts_pkg;

  localparam int CHAR_W       = 8;
  localparam int TOTAL_W      = 63;
  localparam int VALUE_BITS_D = 63;
  localparam int SCALE_W      = 20;
  localparam int DIGIT_W      = 4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_SIGNED,
    PH_DIGITS,
    PH_BOUNDARY
  } phase_t;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [SCALE_W-1:0] SECONDS = 20'd1;
  localparam logic [SCALE_W-1:0] MINUTES = SECONDS * 20'd60;
  localparam logic [SCALE_W-1:0] HOURS   = MINUTES * 20'd60;
  localparam logic [SCALE_W-1:0] DAYS    = HOURS * 20'd24;
  localparam logic [SCALE_W-1:0] WEEKS   = DAYS * 20'd7;

  // Zero marks a letter that is not a unit.
  function automatic logic [SCALE_W-1:0] unit_scale(input logic [CHAR_W-1:0] c);
    logic [SCALE_W-1:0] s;
    case (c)
      8'h73, 8'h53: s = SECONDS;
      8'h6d, 8'h4d: s = MINUTES;
      8'h68, 8'h48: s = HOURS;
      8'h64, 8'h44: s = DAYS;
      8'h77, 8'h57: s = WEEKS;
      default:      s = '0;
    endcase
    return s;
  endfunction

  function automatic logic is_ws(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/dsts_if.sv -----
`default_nettype none
interface dsts_in_if;
  logic                         valid;
  logic                         ready;
  logic [dsts_pkg::CHAR_W-1:0]  character;
  logic                         end_of_string;

  modport source (output valid, output character, output end_of_string, input ready);
  modport sink   (input valid, input character, input end_of_string, output ready);
endinterface

interface dsts_out_if;
  logic                         valid;
  logic                         ready;
  logic [dsts_pkg::TOTAL_W-1:0] total_seconds;
  logic                         invalid;

  modport source (output valid, output total_seconds, output invalid, input ready);
  modport sink   (input valid, input total_seconds, input invalid, output ready);
endinterface
`default_nettype wire

// ----- rtl/duration_string_to_seconds_top.sv -----
`default_nettype none
// Channel   Modport  Payload                         Moves
// in_chan   sink     character[7:0], end_of_string   one string byte, or the terminator
// out_chan  source   total_seconds[62:0], invalid    one result per terminator
//
// One item per cycle while in_chan.ready is high: each byte updates the parse state in the cycle it is taken.
// The terminator's result appears in the output register in the next cycle; the
// critical path is a constant unit multiply followed by the total add.
// rst_n (synchronous) returns the parser to an empty string and drops any result.
// in_chan.ready falls only while a result sits in the output register and
// out_chan.ready is low.
module duration_string_to_seconds_top #(
  parameter int VALUE_BITS = dsts_pkg::VALUE_BITS_D
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dsts_in_if.sink     in_chan,
  dsts_out_if.source  out_chan
);

  localparam int VB = VALUE_BITS;
  localparam int TW = dsts_pkg::TOTAL_W;
  localparam int PW = VB + dsts_pkg::SCALE_W;
  localparam int AW = VB + dsts_pkg::DIGIT_W;
  localparam logic [VB-1:0] MAXV = '1;

  dsts_pkg::phase_t phase_r, phase_nxt;
  logic [VB-1:0]    seg_val_r, seg_val_nxt;
  logic             seg_neg_r, seg_neg_nxt;
  logic             seg_ovf_r, seg_ovf_nxt;
  logic [VB-1:0]    total_r, total_nxt;
  logic             err_r, err_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [TW-1:0]    out_total_r, out_total_nxt;
  logic             out_invalid_r, out_invalid_nxt;

  logic                              in_accept;
  logic [dsts_pkg::CHAR_W-1:0]       c;
  logic                              is_digit;
  logic [dsts_pkg::DIGIT_W-1:0]      digit;
  logic [dsts_pkg::SCALE_W-1:0]      letter_scale;
  logic [dsts_pkg::SCALE_W-1:0]      sel_scale;
  logic [PW-1:0]                     prod;
  logic [VB:0]                       sum;
  logic                              fin_ok;
  logic [AW-1:0]                     acc;
  logic                              acc_ovf;
  logic                              ok;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_accept     = in_chan.valid && in_chan.ready;
  assign c             = in_chan.character;

  assign is_digit     = (c >= dsts_pkg::CH_ZERO) && (c <= dsts_pkg::CH_NINE);
  assign digit        = dsts_pkg::DIGIT_W'(c - dsts_pkg::CH_ZERO);
  assign letter_scale = dsts_pkg::unit_scale(c);
  assign sel_scale    = in_chan.end_of_string ? dsts_pkg::SECONDS : letter_scale;

  // Close the segment: scale by a constant per unit, then add to the running total.
  always_comb begin
    case (sel_scale)
      dsts_pkg::MINUTES: prod = PW'(seg_val_r) * PW'(dsts_pkg::MINUTES);
      dsts_pkg::HOURS:   prod = PW'(seg_val_r) * PW'(dsts_pkg::HOURS);
      dsts_pkg::DAYS:    prod = PW'(seg_val_r) * PW'(dsts_pkg::DAYS);
      dsts_pkg::WEEKS:   prod = PW'(seg_val_r) * PW'(dsts_pkg::WEEKS);
      default:           prod = PW'(seg_val_r);
    endcase
  end

  assign sum    = {1'b0, total_r} + {1'b0, prod[VB-1:0]};
  assign fin_ok = !seg_ovf_r && !(seg_neg_r && (seg_val_r != '0)) &&
                  !(|prod[PW-1:VB]) && !sum[VB];

  // Next digit: value * 10 + d as shifts and adds.
  assign acc     = (AW'(seg_val_r) << 3) + (AW'(seg_val_r) << 1) + AW'(digit);
  assign acc_ovf = seg_ovf_r || (|acc[AW-1:VB]);

  always_comb begin
    phase_nxt       = phase_r;
    seg_val_nxt     = seg_val_r;
    seg_neg_nxt     = seg_neg_r;
    seg_ovf_nxt     = seg_ovf_r;
    total_nxt       = total_r;
    err_nxt         = err_r;
    out_total_nxt   = out_total_r;
    out_invalid_nxt = out_invalid_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    ok              = 1'b0;

    if (in_accept) begin
      if (in_chan.end_of_string) begin
        case (phase_r)
          dsts_pkg::PH_DIGITS:   ok = !err_r && fin_ok;
          dsts_pkg::PH_BOUNDARY: ok = !err_r;
          default:               ok = 1'b0;
        endcase
        out_valid_nxt   = 1'b1;
        out_invalid_nxt = !ok;
        if (!ok) begin
          out_total_nxt = '0;
        end else if (phase_r == dsts_pkg::PH_DIGITS) begin
          out_total_nxt = TW'(sum[VB-1:0]);
        end else begin
          out_total_nxt = TW'(total_r);
        end
        // Start the next string from scratch.
        phase_nxt   = dsts_pkg::PH_IDLE;
        seg_val_nxt = '0;
        seg_neg_nxt = 1'b0;
        seg_ovf_nxt = 1'b0;
        total_nxt   = '0;
        err_nxt     = 1'b0;
      end else if (!err_r) begin
        if (phase_r == dsts_pkg::PH_DIGITS) begin
          if (is_digit) begin
            seg_val_nxt = acc_ovf ? MAXV : acc[VB-1:0];
            seg_ovf_nxt = acc_ovf;
          end else if ((letter_scale != '0) && fin_ok) begin
            total_nxt   = sum[VB-1:0];
            seg_val_nxt = '0;
            seg_neg_nxt = 1'b0;
            seg_ovf_nxt = 1'b0;
            phase_nxt   = dsts_pkg::PH_BOUNDARY;
          end else begin
            err_nxt = 1'b1;
          end
        end else if (is_digit) begin
          seg_val_nxt = VB'(digit);
          seg_ovf_nxt = 1'b0;
          phase_nxt   = dsts_pkg::PH_DIGITS;
        end else if ((phase_r != dsts_pkg::PH_SIGNED) && dsts_pkg::is_ws(c)) begin
          phase_nxt = dsts_pkg::PH_LEAD;
        end else if ((phase_r != dsts_pkg::PH_SIGNED) &&
                     ((c == dsts_pkg::CH_PLUS) || (c == dsts_pkg::CH_MINUS))) begin
          seg_neg_nxt = (c == dsts_pkg::CH_MINUS);
          phase_nxt   = dsts_pkg::PH_SIGNED;
        end else begin
          err_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dsts_pkg::PH_IDLE;
      seg_val_r   <= '0;
      seg_neg_r   <= 1'b0;
      seg_ovf_r   <= 1'b0;
      total_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      seg_val_r   <= seg_val_nxt;
      seg_neg_r   <= seg_neg_nxt;
      seg_ovf_r   <= seg_ovf_nxt;
      total_r     <= total_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_total_r   <= out_total_nxt;
    out_invalid_r <= out_invalid_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.total_seconds = out_total_r;
  assign out_chan.invalid       = out_invalid_r;

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_chan.end_of_string |=> out_valid_r)
    else $error("terminator did not load a result");

  a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_chan.end_of_string |=>
      phase_r == dsts_pkg::PH_IDLE && total_r == '0 && !err_r)
    else $error("parser not cleared after terminator");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_invalid_r |-> out_total_r == '0)
    else $error("invalid result carries a nonzero total");

  a_error_freezes_total: assert property (@(posedge clk) disable iff (!rst_n)
    err_r && !(in_accept && in_chan.end_of_string) |=> $stable(total_r) && err_r)
    else $error("total changed after an error");

  a_overflow_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    seg_ovf_r |-> seg_val_r == MAXV)
    else $error("overflowed segment not saturated");

endmodule
`default_nettype wire

// ----- tb/sv/tb_duration_string_to_seconds_top.sv -----
`default_nettype none
module tb_duration_string_to_seconds_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          VBITS        = dsts_pkg::VALUE_BITS_D;
  localparam logic [63:0] MAX_VALUE    = (64'd1 << VBITS) - 64'd1;
  localparam int          LIMIT_CYCLES = 200000;
  localparam int          RANDOM_ITEMS = 1250;

  // Running parse of the string plus the totals still owed by the block.
  class seconds_tally;
    typedef struct packed {
      logic [dsts_pkg::TOTAL_W-1:0] total;
      logic                         invalid;
    } duration_result_t;

    dsts_pkg::phase_t   phase;
    logic [63:0]        seg_value;
    bit                 seg_neg;
    bit                 seg_ovf;
    logic [63:0]        sum;
    bit                 bad;
    duration_result_t   pending_totals[$];
    int                 mismatches;

    function new();
      restart();
      mismatches = 0;
    endfunction

    function void restart();
      phase     = dsts_pkg::PH_IDLE;
      seg_value = '0;
      seg_neg   = 1'b0;
      seg_ovf   = 1'b0;
      sum       = '0;
      bad       = 1'b0;
    endfunction

    function logic [63:0] unit_mult(logic [7:0] ch);
      case (ch)
        "s", "S": return 64'd1;
        "m", "M": return 64'd60;
        "h", "H": return 64'd3600;
        "d", "D": return 64'd86400;
        "w", "W": return 64'd604800;
        default:  return 64'd0;
      endcase
    endfunction

    // Scale the current segment and add it to the sum; 0 on any overflow or a negative nonzero segment.
    function bit close_segment(logic [63:0] scale);
      logic [63:0] v;
      v = seg_value;
      if (seg_ovf) return 1'b0;
      if (seg_neg && v != 0) return 1'b0;
      if (v > MAX_VALUE / scale) return 1'b0;
      v = v * scale;
      if (v > MAX_VALUE - sum) return 1'b0;
      sum       = sum + v;
      seg_value = '0;
      seg_neg   = 1'b0;
      seg_ovf   = 1'b0;
      return 1'b1;
    endfunction

    function void take_char(logic [7:0] ch, logic eos);
      logic [63:0]      d;
      logic [63:0]      scale;
      bit               ok;
      bit               is_digit;
      bit               is_space;
      duration_result_t r;
      is_digit = (ch >= dsts_pkg::CH_ZERO) && (ch <= dsts_pkg::CH_NINE);
      is_space = (ch == dsts_pkg::CH_SPACE) ||
                 (ch >= dsts_pkg::CH_TAB && ch <= dsts_pkg::CH_CR);
      d        = 64'(ch - dsts_pkg::CH_ZERO);
      if (eos) begin
        ok = !bad;
        if (ok) begin
          if (phase == dsts_pkg::PH_DIGITS) ok = close_segment(64'd1);
          else if (phase != dsts_pkg::PH_BOUNDARY) ok = 1'b0;
        end
        r.total   = ok ? sum[dsts_pkg::TOTAL_W-1:0] : '0;
        r.invalid = !ok;
        pending_totals.push_back(r);
        restart();
        return;
      end
      if (bad) return;
      if (phase == dsts_pkg::PH_DIGITS) begin
        if (is_digit) begin
          if (seg_ovf || seg_value > (MAX_VALUE - d) / 64'd10) begin
            seg_ovf   = 1'b1;
            seg_value = MAX_VALUE;
          end else begin
            seg_value = seg_value * 64'd10 + d;
          end
        end else begin
          scale = unit_mult(ch);
          if (scale == 0 || !close_segment(scale)) bad = 1'b1;
          else phase = dsts_pkg::PH_BOUNDARY;
        end
        return;
      end
      if (is_digit) begin
        seg_value = d;
        seg_ovf   = 1'b0;
        phase     = dsts_pkg::PH_DIGITS;
      end else if (phase != dsts_pkg::PH_SIGNED && is_space) begin
        phase = dsts_pkg::PH_LEAD;
      end else if (phase != dsts_pkg::PH_SIGNED &&
                   (ch == dsts_pkg::CH_PLUS || ch == dsts_pkg::CH_MINUS)) begin
        seg_neg = (ch == dsts_pkg::CH_MINUS);
        phase   = dsts_pkg::PH_SIGNED;
      end else begin
        bad = 1'b1;
      end
    endfunction

    function void match_total(logic [dsts_pkg::TOTAL_W-1:0] total, logic invalid);
      duration_result_t e;
      if (pending_totals.size() == 0) begin
        $error("unexpected result: total_seconds %0d invalid %0d", total, invalid);
        mismatches++;
        return;
      end
      e = pending_totals.pop_front();
      if (total !== e.total) begin
        $error("total_seconds: expected %0d, actual %0d", e.total, total);
        mismatches++;
      end
      if (invalid !== e.invalid) begin
        $error("invalid: expected %0d, actual %0d", e.invalid, invalid);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   items_sent;
  int   burst_left;
  int   rx_mode;
  int   rx_left;

  seconds_tally tally = new();

  dsts_in_if  in_if ();
  dsts_out_if out_if ();

  duration_string_to_seconds_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_n) begin
      if (in_if.valid && in_if.ready) tally.take_char(in_if.character, in_if.end_of_string);
      if (out_if.valid && out_if.ready) tally.match_total(out_if.total_seconds, out_if.invalid);
    end
  end

  // Receiver: switch between free flow, random stalls, heavy stalls and full blocks.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(5, 60);
    end else begin
      rx_left = rx_left - 1;
    end
    case (rx_mode)
      0:       out_if.ready <= 1'b1;
      1:       out_if.ready <= 1'($urandom_range(0, 1));
      2:       out_if.ready <= ($urandom_range(0, 3) == 0);
      default: out_if.ready <= 1'b0;
    endcase
  end

  // Call at a falling edge; returns at a falling edge after the item is taken and any burst pause.
  task automatic send_item(logic [7:0] ch, logic eos);
    in_if.valid         <= 1'b1;
    in_if.character     <= ch;
    in_if.end_of_string <= eos;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
    end
  endtask

  task automatic send_string(logic [7:0] text[$]);
    foreach (text[i]) send_item(text[i], 1'b0);
    // terminator carries a random, ignored character
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(string s);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_string(q);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (tally.pending_totals.size() != 0);
  endtask

  initial begin
    logic [7:0] q[$];
    string      units;
    string      junk;
    int         nseg;
    int         ndig;
    int         pos;
    int         r;
    int         strings;
    bit         neg;
    bit         zero_neg;
    units               = "smhdwSMHDW";
    junk                = "0123456789+- smhdwx.";
    clk                 = 1'b0;
    rst_n               = 1'b0;
    cycle_count         = 0;
    items_sent          = 0;
    burst_left          = 8;
    rx_mode             = 0;
    rx_left             = 0;
    strings             = 0;
    in_if.valid         = 1'b0;
    in_if.character     = '0;
    in_if.end_of_string = 1'b0;
    out_if.ready        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_text("");
    send_text("0");
    send_text("+");
    send_text(" -");
    send_text("+-5");
    send_text("+ 5");
    send_text("x5");
    send_text("5s ");
    send_text("5 s");
    send_text("5x");
    send_text("-5");
    send_text("-0");
    send_text("+42");
    send_text("1w2d3h4m5s");
    send_text("1W2D3H4M5S");
    send_text("\011\012\0137m\014\0158h 9");
    send_text("9223372036854775807");
    send_text("9223372036854775808");
    send_text("99999999999999999999999s");
    send_text("15250284452472w");
    send_text("9223372036854775807s1");
    send_text("5s5s?9w");
    send_text("000000000000000000000000000001m\377");
    q = {};
    q.push_back("3");
    q.push_back(8'h00);
    q.push_back("s");
    send_string(q);
    wait_drained();

    while (items_sent < RANDOM_ITEMS) begin
      q = {};
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 1)) q.push_back(8'($urandom_range(0, 255)));
          else q.push_back(junk[$urandom_range(0, junk.len() - 1)]);
        end
      end else begin
        nseg = $urandom_range(1, 4);
        for (int s = 0; s < nseg; s++) begin
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) begin
              r = $urandom_range(9, 14);
              q.push_back(r == 14 ? dsts_pkg::CH_SPACE : 8'(r));
            end
          end
          r        = $urandom_range(0, 7);
          neg      = (r == 1);
          zero_neg = neg && ($urandom_range(0, 2) != 0);
          if (r == 0) q.push_back(dsts_pkg::CH_PLUS);
          if (neg) q.push_back(dsts_pkg::CH_MINUS);
          ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 21) : $urandom_range(1, 4);
          repeat (ndig) begin
            if (zero_neg) q.push_back(dsts_pkg::CH_ZERO);
            else q.push_back(dsts_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
          end
          if (s < nseg - 1 || $urandom_range(0, 2) != 0) q.push_back(units[$urandom_range(0, 9)]);
        end
        // break a fraction of the well-formed strings
        if ($urandom_range(0, 4) == 0) begin
          pos = $urandom_range(0, q.size() - 1);
          if ($urandom_range(0, 1)) q[pos] = 8'($urandom_range(0, 255));
          else q.insert(pos, 8'($urandom_range(0, 255)));
        end
      end
      send_string(q);
      strings++;
      if (strings % 40 == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (tally.pending_totals.size() != 0)
      $error("%0d results never arrived", tally.pending_totals.size());
    if (tally.mismatches == 0 && tally.pending_totals.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
